@@ rtl/lpfh_pkg.sv @@
package lpfh_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;

  localparam logic [CfgIndexWidth-1:0] REG_MIN_LENGTH      = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_MAX_LENGTH      = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_FRAME_TYPE      = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_HUNT_TIMEOUT    = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_PAYLOAD_TIMEOUT = 3'd4;

  localparam logic [15:0] MIN_LENGTH_RESET      = 16'd28;
  localparam logic [15:0] MAX_LENGTH_RESET      = 16'd188;
  localparam logic [7:0]  FRAME_TYPE_RESET      = 8'd1;
  localparam logic [15:0] HUNT_TIMEOUT_RESET    = 16'd2000;
  localparam logic [15:0] PAYLOAD_TIMEOUT_RESET = 16'd2000;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic [15:0] min_length;
    logic [15:0] max_length;
    logic [7:0]  frame_type;
    logic [15:0] hunt_timeout;
    logic [15:0] payload_timeout;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  out_byte;
    logic [15:0] frame_length;
    logic        first;
    logic        last;
    logic        aborted;
  } result_t;

endpackage

@@ rtl/lpfh_core.sv @@
module lpfh_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             operation,
  input  logic [7:0]       data_byte,
  input  lpfh_pkg::cfg_t   cfg,
  output lpfh_pkg::result_t res,
  output logic             in_payload
);
  import lpfh_pkg::*;

  logic [7:0]  window_bytes [2];
  logic [1:0]  window_fill;
  logic [15:0] current_length;
  logic [15:0] byte_index;
  logic [15:0] tick_count;

  logic [7:0]  window_bytes_next [2];
  logic [1:0]  window_fill_next;
  logic        in_payload_next;
  logic [15:0] current_length_next;
  logic [15:0] byte_index_next;
  logic [15:0] tick_count_next;

  logic [15:0] limit;
  logic [15:0] tick_inc;
  logic [15:0] index_inc;
  logic [15:0] header_length;
  logic        header_ok;

  always_comb begin
    limit         = in_payload ? cfg.payload_timeout : cfg.hunt_timeout;
    tick_inc      = tick_count + 16'd1;
    index_inc     = byte_index + 16'd1;
    header_length = {window_bytes[0], window_bytes[1]};
    header_ok     = (header_length >= cfg.min_length) && (header_length <= cfg.max_length)
                    && (data_byte == cfg.frame_type);

    window_bytes_next   = window_bytes;
    window_fill_next    = window_fill;
    in_payload_next     = in_payload;
    current_length_next = current_length;
    byte_index_next     = byte_index;
    tick_count_next     = tick_count;

    res.valid        = 1'b0;
    res.out_byte     = data_byte;
    res.frame_length = current_length;
    res.first        = 1'b0;
    res.last         = 1'b0;
    res.aborted      = 1'b0;

    if (operation == OP_TICK) begin
      tick_count_next = tick_inc;
      if (tick_inc >= limit) begin
        if (in_payload) begin
          res.valid    = 1'b1;
          res.out_byte = 8'd0;
          res.aborted  = 1'b1;
        end
        window_bytes_next   = '{8'd0, 8'd0};
        window_fill_next    = 2'd0;
        in_payload_next     = 1'b0;
        current_length_next = 16'd0;
        byte_index_next     = 16'd0;
        tick_count_next     = 16'd0;
      end
    end else if (in_payload) begin
      res.valid       = 1'b1;
      byte_index_next = index_inc;
      if (index_inc >= current_length) begin
        res.last            = 1'b1;
        window_bytes_next   = '{8'd0, 8'd0};
        window_fill_next    = 2'd0;
        in_payload_next     = 1'b0;
        current_length_next = 16'd0;
        byte_index_next     = 16'd0;
        tick_count_next     = 16'd0;
      end
    end else if (window_fill < 2'd2) begin
      window_bytes_next[window_fill[0]] = data_byte;
      window_fill_next                  = window_fill + 2'd1;
    end else if (header_ok) begin
      res.valid         = 1'b1;
      res.first         = 1'b1;
      res.frame_length  = header_length;
      window_bytes_next = '{8'd0, 8'd0};
      window_fill_next  = 2'd0;
      tick_count_next   = 16'd0;
      if (header_length <= 16'd1) begin
        res.last            = 1'b1;
        in_payload_next     = 1'b0;
        current_length_next = 16'd0;
        byte_index_next     = 16'd0;
      end else begin
        in_payload_next     = 1'b1;
        current_length_next = header_length;
        byte_index_next     = 16'd1;
      end
    end else begin
      window_bytes_next[0] = window_bytes[1];
      window_bytes_next[1] = data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bytes   <= '{8'd0, 8'd0};
      window_fill    <= 2'd0;
      in_payload     <= 1'b0;
      current_length <= 16'd0;
      byte_index     <= 16'd0;
      tick_count     <= 16'd0;
    end else if (step) begin
      window_bytes   <= window_bytes_next;
      window_fill    <= window_fill_next;
      in_payload     <= in_payload_next;
      current_length <= current_length_next;
      byte_index     <= byte_index_next;
      tick_count     <= tick_count_next;
    end
  end

endmodule

@@ rtl/length_prefixed_frame_hunter_unit.sv @@
// Channel  Direction  Payload
// s_*      in         tdata = data_byte; tuser = operation (1 = tick)
// m_*      out        tdata = out_byte, frame_length; tlast = last; tuser = first, aborted
// cfg_*    in         cfg_index selects the register, cfg_data is written when cfg_we is high
//
// An accepted item waits in the input register; its result is loaded into the result register
// when the core steps, which happens while the output is free (m_tvalid low or m_tready high).
// A new item is accepted in every cycle while results are taken; the rate is one item a cycle.
// Reset is synchronous and active high; it restores the register defaults and starts hunting.
// When a result waits with m_tready low, at most one further item waits in the input register before s_tready drops.
module length_prefixed_frame_hunter_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,   // data_byte[7:0]
  input  logic                                 s_tuser,   // operation
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [23:0]                          m_tdata,   // out_byte[7:0], frame_length[23:8]
  output logic                                 m_tlast,
  output logic [1:0]                           m_tuser,   // first[0], aborted[1]
  input  logic                                 cfg_we,
  input  logic [lpfh_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [lpfh_pkg::CfgDataWidth-1:0]    cfg_data
);
  import lpfh_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    core_in_payload;

  logic       in_valid;
  logic       in_op;
  logic [7:0] in_byte;
  logic       advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_length      <= MIN_LENGTH_RESET;
      cfg.max_length      <= MAX_LENGTH_RESET;
      cfg.frame_type      <= FRAME_TYPE_RESET;
      cfg.hunt_timeout    <= HUNT_TIMEOUT_RESET;
      cfg.payload_timeout <= PAYLOAD_TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_LENGTH:      cfg.min_length      <= cfg_data;
        REG_MAX_LENGTH:      cfg.max_length      <= cfg_data;
        REG_FRAME_TYPE:      cfg.frame_type      <= cfg_data[7:0];
        REG_HUNT_TIMEOUT:    cfg.hunt_timeout    <= cfg_data;
        REG_PAYLOAD_TIMEOUT: cfg.payload_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op   <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  lpfh_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .operation  (in_op),
    .data_byte  (in_byte),
    .cfg        (cfg),
    .res        (res),
    .in_payload (core_in_payload)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      m_tdata <= {res.frame_length, res.out_byte};
      m_tlast <= res.last;
      m_tuser <= {res.aborted, res.first};
    end
  end

  a_first_not_aborted: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("first and aborted set on one result");

  a_abort_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tdata[7:0] == 8'd0 && !m_tlast))
    else $error("aborted result carries a byte or last");

  a_header_opens_payload: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0] && !m_tlast) |-> core_in_payload)
    else $error("frame start shown while the core is hunting");

  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid))
    else $error("input stalled with a free stage");

endmodule

@@ tb/sv/length_prefixed_frame_hunter_unit_tb.sv @@
`timescale 1ns / 1ps

module length_prefixed_frame_hunter_unit_tb;
  import lpfh_pkg::*;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } serial_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] frame_length;
    logic        first;
    logic        last;
    logic        aborted;
  } frame_out_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [7:0]               s_tdata = '0;
  logic                     s_tuser = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [23:0]              m_tdata;
  logic                     m_tlast;
  logic [1:0]               m_tuser;
  logic                     cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data = '0;

  serial_item_t pending_items[$];
  frame_out_t   expected_frames[$];
  int unsigned  queued_count;
  int unsigned  mismatch_count;
  bit           in_fire;
  bit           calm;
  bit           hold_request;
  bit           hold_started;
  int           send_gap;
  int           recv_stall;
  int           hold_left;
  cfg_t         stim_cfg;

  // Predictor state.
  cfg_t         model_cfg;
  logic [7:0]   win [2];
  logic [1:0]   win_fill;
  logic         in_payload;
  logic [15:0]  cur_length;
  logic [15:0]  byte_idx;
  logic [15:0]  tick_cnt;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  length_prefixed_frame_hunter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  task automatic restart_hunt();
    win[0] = '0;
    win[1] = '0;
    win_fill = '0;
    in_payload = 1'b0;
    cur_length = '0;
    byte_idx = '0;
    tick_cnt = '0;
  endtask

  task automatic hunt_predict(input logic op, input logic [7:0] b, output bit has,
                              output frame_out_t r);
    logic [15:0] limit;
    logic [15:0] hdr_len;
    has = 1'b0;
    r = '0;
    if (op == OP_TICK) begin
      limit = in_payload ? model_cfg.payload_timeout : model_cfg.hunt_timeout;
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= limit) begin
        if (in_payload) begin
          has = 1'b1;
          r = '{out_byte: 8'h00, frame_length: cur_length, first: 1'b0, last: 1'b0,
                aborted: 1'b1};
        end
        restart_hunt();
      end
    end else if (in_payload) begin
      byte_idx = byte_idx + 16'd1;
      has = 1'b1;
      r = '{out_byte: b, frame_length: cur_length, first: 1'b0,
            last: (byte_idx >= cur_length), aborted: 1'b0};
      if (byte_idx >= cur_length) restart_hunt();
    end else if (win_fill < 2'd2) begin
      win[win_fill[0]] = b;
      win_fill = win_fill + 2'd1;
    end else begin
      hdr_len = {win[0], win[1]};
      if (hdr_len >= model_cfg.min_length && hdr_len <= model_cfg.max_length &&
          b == model_cfg.frame_type) begin
        has = 1'b1;
        r = '{out_byte: b, frame_length: hdr_len, first: 1'b1, last: (hdr_len <= 16'd1),
              aborted: 1'b0};
        restart_hunt();
        if (hdr_len > 16'd1) begin
          in_payload = 1'b1;
          cur_length = hdr_len;
          byte_idx = 16'd1;
        end
      end else begin
        win[0] = win[1];
        win[1] = b;
      end
    end
  endtask

  always @(posedge clk) begin
    frame_out_t got;
    frame_out_t want;
    frame_out_t predicted;
    bit         produced;
    if (rst) begin
      model_cfg = '{min_length: MIN_LENGTH_RESET, max_length: MAX_LENGTH_RESET,
                    frame_type: FRAME_TYPE_RESET, hunt_timeout: HUNT_TIMEOUT_RESET,
                    payload_timeout: PAYLOAD_TIMEOUT_RESET};
      restart_hunt();
      in_fire <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_LENGTH:      model_cfg.min_length = cfg_data;
          REG_MAX_LENGTH:      model_cfg.max_length = cfg_data;
          REG_FRAME_TYPE:      model_cfg.frame_type = cfg_data[7:0];
          REG_HUNT_TIMEOUT:    model_cfg.hunt_timeout = cfg_data;
          REG_PAYLOAD_TIMEOUT: model_cfg.payload_timeout = cfg_data;
          default: ;
        endcase
      end
      in_fire <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        hunt_predict(s_tuser, s_tdata, produced, predicted);
        if (produced) expected_frames.push_back(predicted);
      end
      if (m_tvalid && m_tready) begin
        got = '{out_byte: m_tdata[7:0], frame_length: m_tdata[23:8], first: m_tuser[0],
                last: m_tlast, aborted: m_tuser[1]};
        if (expected_frames.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected item: byte %h length %h first %b last %b aborted %b",
                     got.out_byte, got.frame_length, got.first, got.last, got.aborted);
        end else begin
          want = expected_frames.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: expected byte %h length %h first %b last %b aborted %b",
                       want.out_byte, want.frame_length, want.first, want.last, want.aborted);
              $display("          got      byte %h length %h first %b last %b aborted %b",
                       got.out_byte, got.frame_length, got.first, got.last, got.aborted);
            end
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    serial_item_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        item = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= item.op;
        s_tdata <= item.data;
        if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 9);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_request && !hold_started) begin
      hold_started = 1'b1;
      hold_left = 47;
      m_tready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      recv_stall = $urandom_range(0, 8);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    pending_items.push_back('{op: OP_BYTE, data: b});
    queued_count++;
  endtask

  task automatic push_tick();
    pending_items.push_back('{op: OP_TICK, data: 8'($urandom_range(0, 255))});
    queued_count++;
  endtask

  task automatic set_config(input cfg_t c);
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_MIN_LENGTH;
    cfg_data <= c.min_length;
    @(negedge clk);
    cfg_index <= REG_MAX_LENGTH;
    cfg_data <= c.max_length;
    @(negedge clk);
    cfg_index <= REG_FRAME_TYPE;
    cfg_data <= {junk, c.frame_type};
    @(negedge clk);
    cfg_index <= REG_HUNT_TIMEOUT;
    cfg_data <= c.hunt_timeout;
    @(negedge clk);
    cfg_index <= REG_PAYLOAD_TIMEOUT;
    cfg_data <= c.payload_timeout;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    stim_cfg = c;
  endtask

  task automatic drain_and_settle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_items.size() != 0 || s_tvalid || expected_frames.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic gen_traffic(input int unsigned n, input int unsigned lo,
                             input int unsigned hi, input int unsigned abort_pct);
    int unsigned stop_at;
    int unsigned r;
    int unsigned len;
    int unsigned body;
    int unsigned burst;
    stop_at = queued_count + n;
    while (queued_count < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        r = $urandom_range(0, 99);
        if (r < 15) len = lo;
        else if (r < 30) len = hi;
        else len = $urandom_range(lo, (hi > lo + 12) ? lo + 12 : hi);
        push_byte(len[15:8]);
        push_byte(len[7:0]);
        push_byte(stim_cfg.frame_type);
        if (len >= 2) begin
          if ((len - 1 > 12 || $urandom_range(0, 99) < abort_pct) &&
              stim_cfg.payload_timeout <= 64) begin
            body = $urandom_range(0, (len - 2 > 12) ? 12 : len - 2);
            repeat (body) push_byte(8'($urandom_range(0, 255)));
            repeat (stim_cfg.payload_timeout) push_tick();
          end else begin
            repeat (len - 1) begin
              if ($urandom_range(0, 99) < 3) push_tick();
              push_byte(8'($urandom_range(0, 255)));
            end
          end
        end
      end else if (r < 78) begin
        if ($urandom_range(0, 1) == 1) begin
          len = $urandom_range(lo, hi);
          push_byte(len[15:8]);
          push_byte(len[7:0]);
          push_byte(stim_cfg.frame_type ^ 8'($urandom_range(1, 255)));
        end else begin
          repeat (3) push_byte(8'($urandom_range(0, 255)));
        end
      end else if (r < 90) begin
        push_byte(8'($urandom_range(0, 255)));
      end else begin
        burst = $urandom_range(1, (stim_cfg.hunt_timeout < 8) ? stim_cfg.hunt_timeout + 1 : 8);
        repeat (burst) push_tick();
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_config('{min_length: 16'd0, max_length: 16'd5, frame_type: 8'hFF,
                 hunt_timeout: 16'd3, payload_timeout: 16'd2});
    // Zero and one length headers give a frame of the type byte alone.
    push_byte(8'h00); push_byte(8'h00); push_byte(8'hFF);
    push_byte(8'h00); push_byte(8'h01); push_byte(8'hFF);
    // Length at the upper bound, body bytes at the extremes.
    push_byte(8'h00); push_byte(8'h05); push_byte(8'hFF);
    push_byte(8'h00); push_byte(8'hFF); push_byte(8'h80); push_byte(8'h7F);
    // Length just above the bound is rejected, then a hunt timeout empties the window.
    push_byte(8'h00); push_byte(8'h06); push_byte(8'hFF);
    push_tick(); push_tick(); push_tick();
    push_byte(8'h00); push_byte(8'h02); push_byte(8'hFF); push_byte(8'h55);
    // The payload timeout aborts a partial frame.
    push_byte(8'h00); push_byte(8'h03); push_byte(8'hFF); push_byte(8'h11);
    push_tick(); push_tick();
    drain_and_settle();

    set_config('{min_length: 16'd2, max_length: 16'd12, frame_type: 8'($urandom_range(0, 255)),
                 hunt_timeout: 16'd6, payload_timeout: 16'd4});
    hold_request = 1'b1;
    gen_traffic(250, 2, 12, 15);
    drain_and_settle();

    set_config('{min_length: 16'd0, max_length: 16'hFFFF, frame_type: 8'h00,
                 hunt_timeout: 16'hFFFF, payload_timeout: 16'hFFFF});
    gen_traffic(120, 0, 12, 0);
    drain_and_settle();

    set_config('{min_length: 16'hFFFF, max_length: 16'hFFFF, frame_type: 8'hFF,
                 hunt_timeout: 16'd1, payload_timeout: 16'd1});
    gen_traffic(60, 65535, 65535, 0);
    drain_and_settle();

    // With the maximum below the minimum no header can be accepted.
    set_config('{min_length: 16'd200, max_length: 16'd100, frame_type: 8'h5A,
                 hunt_timeout: 16'd10, payload_timeout: 16'd10});
    gen_traffic(40, 100, 200, 0);
    drain_and_settle();

    calm = 1'b1;
    set_config('{min_length: MIN_LENGTH_RESET, max_length: MAX_LENGTH_RESET,
                 frame_type: FRAME_TYPE_RESET, hunt_timeout: HUNT_TIMEOUT_RESET,
                 payload_timeout: PAYLOAD_TIMEOUT_RESET});
    gen_traffic(150, 28, 188, 0);
    drain_and_settle();

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ length_prefixed_frame_hunter_unit.f @@
rtl/lpfh_pkg.sv
rtl/lpfh_core.sv
rtl/length_prefixed_frame_hunter_unit.sv
tb/sv/length_prefixed_frame_hunter_unit_tb.sv
